// ----- design/fir_lc_pkg.sv -----
// Shared types and constants for the FIR linear-convolution block.
// Item structs, opcodes and the control groups between the top level,
// the tap cells and the multiply-accumulate unit. No dependencies.
package fir_lc_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned CoefIdxW = 6;
  localparam int unsigned TapCntW  = 7;

  localparam logic [TapCntW-1:0] TapCountReset = 7'd32;

  typedef enum logic {
    OpSample = 1'b0,
    OpCoef   = 1'b1
  } op_e;

  typedef struct packed {
    op_e                        op;
    logic signed [SampleW-1:0]  sample;
    logic                       last;
    logic [CoefIdxW-1:0]        coef_index;
    logic signed [SampleW-1:0]  coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] y;
    logic                      saturated;
    logic                      last_out;
  } out_item_t;

  // History line moves shared by every cell
  typedef struct packed {
    logic clear;
    logic shift;
    logic rotate;
  } cell_ctrl_t;

  // Accumulator controls
  typedef struct packed {
    logic clr;
    logic en;
    logic use_tap;
  } mac_ctrl_t;

endpackage

// ----- design/fir_lc_cell.sv -----
// One tap cell: holds one history sample and one coefficient.
// Shifts history forward, rotates both values backward. Uses fir_lc_pkg.
module fir_lc_cell (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  fir_lc_pkg::cell_ctrl_t                 ctrl_i,
  input  logic signed [fir_lc_pkg::SampleW-1:0]  hist_prev_i,
  input  logic signed [fir_lc_pkg::SampleW-1:0]  hist_next_i,
  input  logic signed [fir_lc_pkg::SampleW-1:0]  coef_next_i,
  input  logic                                   coef_we_i,
  input  logic signed [fir_lc_pkg::SampleW-1:0]  coef_i,
  output logic signed [fir_lc_pkg::SampleW-1:0]  hist_o,
  output logic signed [fir_lc_pkg::SampleW-1:0]  coef_o
);

  logic signed [fir_lc_pkg::SampleW-1:0] hist_q, hist_d;
  logic signed [fir_lc_pkg::SampleW-1:0] coef_q, coef_d;

  // Select next history value: clear wins, then shift, then rotate
  always_comb begin
    hist_d = hist_q;
    if (ctrl_i.clear) begin
      hist_d = '0;
    end else if (ctrl_i.shift) begin
      hist_d = hist_prev_i;
    end else if (ctrl_i.rotate) begin
      hist_d = hist_next_i;
    end
  end

  // Select next coefficient: a write wins over rotation
  always_comb begin
    coef_d = coef_q;
    if (coef_we_i) begin
      coef_d = coef_i;
    end else if (ctrl_i.rotate) begin
      coef_d = coef_next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      coef_q <= '0;
    end else begin
      hist_q <= hist_d;
      coef_q <= coef_d;
    end
  end

  assign hist_o = hist_q;
  assign coef_o = coef_q;

endmodule

// ----- design/fir_lc_mac.sv -----
// Multiply-accumulate unit at the head of the cell chain, with output
// rounding and saturation. Uses fir_lc_pkg for widths and control struct.
module fir_lc_mac #(
  parameter int unsigned ACC_WIDTH = 40
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  fir_lc_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [fir_lc_pkg::SampleW-1:0]  hist_i,
  input  logic signed [fir_lc_pkg::SampleW-1:0]  coef_i,
  output logic signed [fir_lc_pkg::SampleW-1:0]  y_o,
  output logic                                   sat_o
);

  localparam int unsigned SW    = fir_lc_pkg::SampleW;
  localparam int unsigned ProdW = 2 * SW;
  localparam int unsigned RndW  = ACC_WIDTH + 1;

  localparam logic signed [RndW-1:0] RoundBias = RndW'(2 ** (SW - 2));
  localparam logic signed [RndW-1:0] MaxY      = RndW'(2 ** (SW - 1) - 1);
  localparam logic signed [RndW-1:0] MinY      = ~MaxY;

  logic signed [ProdW-1:0]     prod_q;
  logic                        pvld_q;
  logic signed [ACC_WIDTH-1:0] acc_q, acc_d;
  logic signed [ACC_WIDTH-1:0] addend;
  logic signed [RndW-1:0]      rnd;
  logic signed [RndW-1:0]      scaled;

  // Register each product before it reaches the adder
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_q <= hist_i * coef_i;
    end
  end

  assign addend = pvld_q ? ACC_WIDTH'(prod_q) : '0;

  // Accumulate modulo 2^ACC_WIDTH
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (ctrl_i.en) begin
      acc_d = acc_q + addend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      acc_q <= acc_d;
      if (ctrl_i.clr) begin
        pvld_q <= 1'b0;
      end else if (ctrl_i.en) begin
        pvld_q <= ctrl_i.use_tap;
      end
    end
  end

  // Round half up, scale back to Q1.15 and clip
  assign rnd    = RndW'(acc_q) + RoundBias;
  assign scaled = rnd >>> (SW - 1);

  always_comb begin
    sat_o = 1'b0;
    y_o   = scaled[SW-1:0];
    if (scaled > MaxY) begin
      sat_o = 1'b1;
      y_o   = MaxY[SW-1:0];
    end else if (scaled < MinY) begin
      sat_o = 1'b1;
      y_o   = MinY[SW-1:0];
    end
  end

endmodule

// ----- design/fir_linear_convolution.sv -----
// Streaming FIR filter giving the full linear convolution of a signal.
// Top level: sequencer, tap cell chain, accumulator and output register.
// Depends on fir_lc_pkg, fir_lc_cell and fir_lc_mac.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_item_i): an item either writes
//   one coefficient (op = coefficient) or pushes one sample. A coefficient
//   item is taken while idle and gives no result. A sample item gives one
//   result; with last set it also gives taps_eff-1 tail results, then the
//   history is cleared.
//   Output channel (out_valid_o/out_ready_i, out_item_o): one result per sample
//   item, plus any tail results. For each result the history and coefficient
//   rings rotate once through the single multiplier at cell 0, then the
//   product register drains into the accumulator, then the rounded result
//   loads into the output register. One item is processed at a time; in_ready_o
//   is high again once its last result sits in the output register.
//   Config: cfg_we_i writes tap_count (cfg_data_i) at once; the user must
//   write it only while idle, as the block itself does not enforce this.
//   Reset clears history, coefficients, flush count and sets tap_count = 32.
//   A stalled receiver holds the output register; the next result then
//   waits in the accumulator until the register frees up.
module fir_linear_convolution #(
  parameter int unsigned TAPS_MAX  = 64,
  parameter int unsigned ACC_WIDTH = 40
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  fir_lc_pkg::in_item_t                 in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output fir_lc_pkg::out_item_t                out_item_o,
  input  logic                                 cfg_we_i,
  input  logic [fir_lc_pkg::TapCntW-1:0]       cfg_data_i
);

  localparam int unsigned SW   = fir_lc_pkg::SampleW;
  localparam int unsigned TcW  = fir_lc_pkg::TapCntW;
  localparam int unsigned CntW = $clog2(TAPS_MAX);
  localparam logic [CntW-1:0] LastCnt = CntW'(TAPS_MAX - 1);
  localparam logic [TcW-1:0]  TapsMax = TcW'(TAPS_MAX);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StMac  = 4'b0010,
    StAdd  = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [TcW-1:0]        flush_q, flush_d;
  logic                  last_q, last_d;
  logic [TcW-1:0]        tap_count_q;
  logic [TcW-1:0]        taps_eff;
  logic                  out_valid_q;
  fir_lc_pkg::out_item_t out_q;

  logic                  in_acc;
  logic                  out_free;
  logic                  out_load;
  logic signed [SW-1:0]  shift_data;
  fir_lc_pkg::cell_ctrl_t cell_ctrl;
  fir_lc_pkg::mac_ctrl_t  mac_ctrl;
  logic signed [SW-1:0]  mac_y;
  logic                  mac_sat;

  logic signed [SW-1:0]  hist [TAPS_MAX];
  logic signed [SW-1:0]  coef [TAPS_MAX];

  // Tap count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= fir_lc_pkg::TapCountReset;
    end else if (cfg_we_i) begin
      tap_count_q <= cfg_data_i;
    end
  end

  // Clamp the tap count into 1..TAPS_MAX
  always_comb begin
    taps_eff = tap_count_q;
    if (tap_count_q == '0) begin
      taps_eff = TcW'(1);
    end else if (tap_count_q > TapsMax) begin
      taps_eff = TapsMax;
    end
  end

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = (state_q == StEmit) && out_free;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    flush_d    = flush_q;
    last_d     = last_q;
    cell_ctrl  = '0;
    mac_ctrl   = '0;
    shift_data = '0;
    unique case (state_q)
      StIdle: begin
        if (in_acc && (in_item_i.op == fir_lc_pkg::OpSample)) begin
          cell_ctrl.shift = 1'b1;
          shift_data      = in_item_i.sample;
          mac_ctrl.clr    = 1'b1;
          cnt_d           = '0;
          last_d          = in_item_i.last;
          flush_d         = in_item_i.last ? taps_eff - TcW'(1) : '0;
          state_d         = StMac;
        end
      end
      StMac: begin
        cell_ctrl.rotate = 1'b1;
        mac_ctrl.en      = 1'b1;
        mac_ctrl.use_tap = (TcW'(cnt_q) < taps_eff);
        cnt_d            = cnt_q + CntW'(1);
        if (cnt_q == LastCnt) begin
          cnt_d   = '0;
          state_d = StAdd;
        end
      end
      StAdd: begin
        // Drain the last product into the accumulator
        mac_ctrl.en = 1'b1;
        state_d     = StEmit;
      end
      StEmit: begin
        if (out_free) begin
          if (flush_q != '0) begin
            // Push a zero and compute the next tail result
            flush_d         = flush_q - TcW'(1);
            cell_ctrl.shift = 1'b1;
            mac_ctrl.clr    = 1'b1;
            state_d         = StMac;
          end else begin
            cell_ctrl.clear = last_q;
            last_d          = 1'b0;
            state_d         = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      flush_q <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      flush_q <= flush_d;
      last_q  <= last_d;
    end
  end

  // Chain of tap cells: shift feeds from cell 0, rotation wraps cell 0 to the last cell
  for (genvar j = 0; j < TAPS_MAX; j++) begin : g_cell
    logic coef_we;
    assign coef_we = in_acc && (in_item_i.op == fir_lc_pkg::OpCoef)
                     && (in_item_i.coef_index == fir_lc_pkg::CoefIdxW'(j));
    fir_lc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .hist_prev_i ((j == 0) ? shift_data : hist[(j + TAPS_MAX - 1) % TAPS_MAX]),
      .hist_next_i (hist[(j + 1) % TAPS_MAX]),
      .coef_next_i (coef[(j + 1) % TAPS_MAX]),
      .coef_we_i   (coef_we),
      .coef_i      (in_item_i.coef_value),
      .hist_o      (hist[j]),
      .coef_o      (coef[j])
    );
  end

  fir_lc_mac #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .hist_i (hist[0]),
    .coef_i (coef[0]),
    .y_o    (mac_y),
    .sat_o  (mac_sat)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.y         <= mac_y;
      out_q.saturated <= mac_sat;
      out_q.last_out  <= last_q && (flush_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- design/fir_lc_checker.sv -----
// Port-level checker for the FIR linear-convolution block, bound to the top.
// Depends on fir_lc_pkg and fir_linear_convolution.
module fir_lc_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input fir_lc_pkg::in_item_t  in_item_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input fir_lc_pkg::out_item_t out_item_o
);

  // Hold a result until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("stalled result changed");

  // A sample item keeps the block busy for its computation
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.op == fir_lc_pkg::OpSample)
    |=> !in_ready_o)
    else $error("sample item did not start a computation");

  // A coefficient write gives no result
  a_coef_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.op == fir_lc_pkg::OpCoef)
    |=> !$rose(out_valid_o))
    else $error("coefficient write produced a result");

endmodule

bind fir_linear_convolution fir_lc_checker u_fir_lc_checker (.*);
